// ===== src/lrnm_pkg.sv =====
package lrnm_pkg;

  localparam int MAX_ORDER = 64;
  localparam int DATA_W    = 27;
  localparam int ORDER_W   = 7;
  localparam int INDEX_W   = 63;
  localparam int CFG_IDX_W = 2;

  localparam int VS_DEPTH = MAX_ORDER;
  localparam int VS_AW    = $clog2(VS_DEPTH);
  localparam int Q_DEPTH  = MAX_ORDER + 1;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int S_DEPTH  = 2 * MAX_ORDER + 2;
  localparam int S_AW     = $clog2(S_DEPTH);
  localparam int BIT_CW   = $clog2(DATA_W);

  localparam logic [DATA_W:0]   PRIME     = 28'd104857601;
  localparam logic [DATA_W+1:0] PRIME_X2  = 29'd209715202;
  localparam logic [S_AW-1:0]   S_Q_BASE  = S_AW'(MAX_ORDER);

  localparam logic [CFG_IDX_W-1:0] CFG_ORDER      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_INDEX = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_BASE_RD,
    ST_BASE_WT,
    ST_TERM_RD,
    ST_TERM_GO,
    ST_TERM_WAIT,
    ST_WRITE,
    ST_CHECK,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    PH_QBUILD,
    PH_PBUILD,
    PH_PMUL,
    PH_QMUL,
    PH_CPP,
    PH_CPQ,
    PH_DIV
  } phase_t;

  function automatic logic [DATA_W-1:0] mod_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= PRIME) s = s - PRIME;
    return s[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] mod_sub(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else s = {1'b0, a} + PRIME - {1'b0, b};
    return s[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] mod_neg(input logic [DATA_W-1:0] a);
    return (a == '0) ? '0 : PRIME[DATA_W-1:0] - a;
  endfunction

  function automatic logic [DATA_W-1:0] reduce_field(input logic [DATA_W-1:0] a);
    return ({1'b0, a} >= PRIME) ? a - PRIME[DATA_W-1:0] : a;
  endfunction

endpackage

// ===== src/lrnm_ram.sv =====
module lrnm_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lrnm_mulmod.sv =====
module lrnm_mulmod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lrnm_pkg::DATA_W-1:0] a,
  input  logic [lrnm_pkg::DATA_W-1:0] b,
  output logic                       done,
  output logic [lrnm_pkg::DATA_W-1:0] product
);
  import lrnm_pkg::*;

  // Interleaved multiply: one bit of b per cycle, msb first, reduced each step.
  logic              busy;
  logic [BIT_CW-1:0] cnt;
  logic [DATA_W-1:0] a_op;
  logic [DATA_W-1:0] b_op;
  logic [DATA_W-1:0] r;
  logic [DATA_W+1:0] t;
  logic [DATA_W+1:0] t_red;

  always_comb begin
    t = {1'b0, r, 1'b0} + (b_op[DATA_W-1] ? {2'b00, a_op} : '0);
    if (t >= PRIME_X2) t_red = t - PRIME_X2;
    else if (t >= {1'b0, PRIME}) t_red = t - {1'b0, PRIME};
    else t_red = t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= BIT_CW'(DATA_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_op <= a;
      b_op <= b;
      r    <= '0;
    end else if (busy) begin
      r    <= t_red[DATA_W-1:0];
      b_op <= {b_op[DATA_W-2:0], 1'b0};
    end
  end

  assign product = r;

  a_prod_reduced: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, product} < PRIME)) else $error("mulmod result not reduced");

endmodule

// ===== src/linear_recurrence_nth_term_mod.sv =====
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  initial_value, coefficient
// m_axis    out  m_axis_tvalid/m_axis_tready  term_value
// cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data (order, term_index)
//
// Load items go in one per cycle; the item that completes a load of k items starts
// the computation and input stalls until the result sits in the output register.
// Each modular multiply runs 27 bit steps in the shared unit; a halving round costs about
// k*k multiply-accumulates, and there are about log2(n/k) rounds, plus k*k/2 for the
// numerator and up to k*k/2 for the series.
// Reset clears control state only; the coefficient stores need no clearing pass.
// A result waiting on m_axis does not block loading of the next run.
module linear_recurrence_nth_term_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [55:0]                   s_axis_tdata,  // initial_value[26:0], coefficient[53:27]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // term_value[26:0]
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lrnm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrnm_pkg::INDEX_W-1:0]  cfg_data
);
  import lrnm_pkg::*;

  state_t state, state_next;
  phase_t phase;

  logic [ORDER_W-1:0] order;
  logic [INDEX_W-1:0] term_index;
  logic [ORDER_W-1:0] load_count;
  logic [ORDER_W-1:0] k_now;
  logic [ORDER_W-1:0] k;
  logic [INDEX_W-1:0] rem;
  logic [ORDER_W-1:0] i_cnt;
  logic [ORDER_W-1:0] j_cnt;
  logic [ORDER_W-1:0] j_hi;
  logic               has_terms;
  logic [DATA_W-1:0]  acc;
  logic               out_valid;
  logic [DATA_W-1:0]  out_data;

  logic               in_acc;
  logic [ORDER_W-1:0] cnt_inc;
  logic               load_done;

  // Sequencer-driven datapath controls.
  logic [S_AW-1:0]    m;
  logic [S_AW-1:0]    m_minus_j;
  logic [ORDER_W-1:0] i_last;
  logic [ORDER_W-1:0] lo_c;
  logic [ORDER_W-1:0] hi_c;
  logic               has_c;
  logic               base_rd;
  logic               sub_op;
  logic [DATA_W-1:0]  base_val;
  logic [DATA_W-1:0]  op_a;
  logic [DATA_W-1:0]  op_b;
  logic               mul_start;
  logic               mul_done;
  logic [DATA_W-1:0]  mul_prod;
  logic               rem_gt_k;

  logic [VS_AW-1:0]   vs_raddr, cs_raddr, p_raddr, p_waddr;
  logic [Q_AW-1:0]    q_raddr, q2_raddr, q_waddr;
  logic [S_AW-1:0]    s_raddr, s_waddr;
  logic               p_we, q_we, s_we;
  logic [DATA_W-1:0]  vs_rdata, cs_rdata, p_rdata, q_rdata, q2_rdata, s_rdata;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(32 - DATA_W){1'b0}}, out_data};

  // Clamp order into 1..MAX_ORDER.
  always_comb begin
    if (order == '0) k_now = ORDER_W'(1);
    else if (order > ORDER_W'(MAX_ORDER)) k_now = ORDER_W'(MAX_ORDER);
    else k_now = order;
  end

  assign cnt_inc   = load_count + 1'b1;
  assign load_done = (cnt_inc >= k_now);
  assign rem_gt_k  = (rem > {{(INDEX_W - ORDER_W){1'b0}}, k});

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      order      <= ORDER_W'(1);
      term_index <= INDEX_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ORDER) order <= cfg_data[ORDER_W-1:0];
      else if (cfg_index == CFG_TERM_INDEX) term_index <= cfg_data;
    end
  end

  // Output index of the element being built; even/odd pick in the halving products.
  always_comb begin
    unique case (phase)
      PH_PMUL: m = {i_cnt, rem[0]};
      PH_QMUL: m = {i_cnt, 1'b0};
      default: m = {1'b0, i_cnt};
    endcase
  end
  assign m_minus_j = m - {1'b0, j_cnt};

  // Loop bounds per phase.
  always_comb begin
    lo_c   = '0;
    hi_c   = '0;
    has_c  = 1'b0;
    i_last = k;
    sub_op = 1'b0;
    unique case (phase)
      PH_QBUILD: i_last = k;
      PH_PBUILD: begin
        i_last = k - 1'b1;
        hi_c   = i_cnt - 1'b1;
        has_c  = (i_cnt != '0);
        sub_op = 1'b1;
      end
      PH_PMUL: begin
        i_last = k - 1'b1;
        lo_c   = (m > {1'b0, k}) ? ORDER_W'(m - {1'b0, k}) : '0;
        hi_c   = (m < {1'b0, k}) ? m[ORDER_W-1:0] : k - 1'b1;
        has_c  = 1'b1;
      end
      PH_QMUL: begin
        i_last = k;
        lo_c   = (m > {1'b0, k}) ? ORDER_W'(m - {1'b0, k}) : '0;
        hi_c   = (m < {1'b0, k}) ? m[ORDER_W-1:0] : k;
        has_c  = 1'b1;
      end
      PH_CPP: i_last = k - 1'b1;
      PH_CPQ: i_last = k;
      PH_DIV: begin
        i_last = rem[ORDER_W-1:0];
        lo_c   = ORDER_W'(1);
        hi_c   = (m < {1'b0, k}) ? m[ORDER_W-1:0] : k;
        has_c  = (i_cnt != '0);
        sub_op = 1'b1;
      end
      default: i_last = k;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_acc && load_done) state_next = ST_INIT;
      ST_INIT:      state_next = ST_BASE_RD;
      ST_BASE_RD:   state_next = ST_BASE_WT;
      ST_BASE_WT:   state_next = has_terms ? ST_TERM_RD : ST_WRITE;
      ST_TERM_RD:   state_next = ST_TERM_GO;
      ST_TERM_GO:   state_next = ST_TERM_WAIT;
      ST_TERM_WAIT: begin
        if (mul_done) state_next = (j_cnt == j_hi) ? ST_WRITE : ST_TERM_RD;
      end
      ST_WRITE: begin
        if (i_cnt != i_last) state_next = ST_BASE_RD;
        else if (phase == PH_DIV) state_next = ST_FIN;
        else if (phase == PH_PBUILD || phase == PH_CPQ) state_next = ST_CHECK;
        else state_next = ST_BASE_RD;
      end
      ST_CHECK:     state_next = ST_BASE_RD;
      ST_FIN:       if (!out_valid || m_axis_tready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Memory addresses, operands and write strobes.
  always_comb begin
    base_rd  = (state == ST_BASE_RD);
    mul_start = (state == ST_TERM_GO);

    vs_raddr = base_rd ? m[VS_AW-1:0] : VS_AW'(m - {1'b0, j_cnt} - 1'b1);
    cs_raddr = base_rd ? VS_AW'(m - 1'b1) : j_cnt[VS_AW-1:0];
    p_raddr  = base_rd ? m[VS_AW-1:0] : j_cnt[VS_AW-1:0];
    q_raddr  = (phase == PH_PMUL) ? m_minus_j[Q_AW-1:0] : j_cnt[Q_AW-1:0];
    q2_raddr = m_minus_j[Q_AW-1:0];
    if (base_rd) s_raddr = (phase == PH_CPQ) ? S_Q_BASE + {1'b0, i_cnt} : {1'b0, i_cnt};
    else s_raddr = m_minus_j;

    // Base term of the element.
    unique case (phase)
      PH_QBUILD: base_val = (i_cnt == '0) ? DATA_W'(1) : mod_neg(cs_rdata);
      PH_PBUILD: base_val = vs_rdata;
      PH_CPP,
      PH_CPQ:    base_val = s_rdata;
      PH_DIV:    base_val = (m < {1'b0, k}) ? p_rdata : '0;
      default:   base_val = '0;
    endcase

    // Product operands; odd coefficients of Q(-x) flip sign.
    unique case (phase)
      PH_PBUILD: begin
        op_a = cs_rdata;
        op_b = vs_rdata;
      end
      PH_PMUL: begin
        op_a = p_rdata;
        op_b = m_minus_j[0] ? mod_neg(q_rdata) : q_rdata;
      end
      PH_QMUL: begin
        op_a = q_rdata;
        op_b = m_minus_j[0] ? mod_neg(q2_rdata) : q2_rdata;
      end
      default: begin
        op_a = q_rdata;
        op_b = s_rdata;
      end
    endcase

    p_we = (state == ST_WRITE) && (phase == PH_PBUILD || phase == PH_CPP);
    q_we = (state == ST_WRITE) && (phase == PH_QBUILD || phase == PH_CPQ);
    s_we = (state == ST_WRITE) &&
           (phase == PH_PMUL || phase == PH_QMUL || phase == PH_DIV);
    p_waddr = i_cnt[VS_AW-1:0];
    q_waddr = i_cnt[Q_AW-1:0];
    s_waddr = (phase == PH_QMUL) ? S_Q_BASE + {1'b0, i_cnt} : {1'b0, i_cnt};
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Load counting and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (in_acc) load_count <= load_done ? '0 : cnt_inc;
      if (state == ST_FIN && (!out_valid || m_axis_tready)) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  // Sequencer counters and accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_QBUILD;
      i_cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          // Capture order and index together with the item that completes the load.
          if (in_acc && load_done) begin
            k   <= k_now;
            rem <= (term_index == '0) ? '0 : term_index - 1'b1;
          end
        end
        ST_INIT: begin
          phase <= PH_QBUILD;
          i_cnt <= '0;
        end
        ST_BASE_RD: begin
          j_cnt     <= lo_c;
          j_hi      <= hi_c;
          has_terms <= has_c;
        end
        ST_BASE_WT: acc <= base_val;
        ST_TERM_WAIT: begin
          if (mul_done) begin
            acc <= sub_op ? mod_sub(acc, mul_prod) : mod_add(acc, mul_prod);
            j_cnt <= j_cnt + 1'b1;
          end
        end
        ST_WRITE: begin
          if (i_cnt != i_last) i_cnt <= i_cnt + 1'b1;
          else begin
            i_cnt <= '0;
            unique case (phase)
              PH_QBUILD: phase <= PH_PBUILD;
              PH_PMUL:   phase <= PH_QMUL;
              PH_QMUL:   phase <= PH_CPP;
              PH_CPP:    phase <= PH_CPQ;
              PH_CPQ:    rem   <= rem >> 1;
              default:   phase <= phase;
            endcase
          end
        end
        ST_CHECK: begin
          phase <= rem_gt_k ? PH_PMUL : PH_DIV;
          i_cnt <= '0;
        end
        ST_FIN: begin
          if (!out_valid || m_axis_tready) out_data <= acc;
        end
        default: i_cnt <= i_cnt;
      endcase
    end
  end

  lrnm_mulmod u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (op_a),
    .b       (op_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  lrnm_ram #(.WIDTH(DATA_W), .DEPTH(VS_DEPTH)) u_vs (
    .clk(clk), .we(in_acc), .waddr(load_count[VS_AW-1:0]),
    .wdata(reduce_field(s_axis_tdata[DATA_W-1:0])),
    .raddr(vs_raddr), .rdata(vs_rdata)
  );

  lrnm_ram #(.WIDTH(DATA_W), .DEPTH(VS_DEPTH)) u_cs (
    .clk(clk), .we(in_acc), .waddr(load_count[VS_AW-1:0]),
    .wdata(reduce_field(s_axis_tdata[2*DATA_W-1:DATA_W])),
    .raddr(cs_raddr), .rdata(cs_rdata)
  );

  lrnm_ram #(.WIDTH(DATA_W), .DEPTH(VS_DEPTH)) u_p (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(acc),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  // Q is kept twice so Q times Q(-x) can read two coefficients at once.
  lrnm_ram #(.WIDTH(DATA_W), .DEPTH(Q_DEPTH)) u_q (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(acc),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  lrnm_ram #(.WIDTH(DATA_W), .DEPTH(Q_DEPTH)) u_q2 (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(acc),
    .raddr(q2_raddr), .rdata(q2_rdata)
  );

  lrnm_ram #(.WIDTH(DATA_W), .DEPTH(S_DEPTH)) u_s (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(acc),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && state != ST_INIT && state != ST_BASE_RD &&
     state != ST_BASE_WT) |->
      ({1'b0, acc} < PRIME)) else $error("accumulator out of range");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_TERM_WAIT)) else $error("multiplier finished unexpectedly");

  a_inner_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TERM_WAIT) |-> (j_cnt <= j_hi)) else $error("inner index past bound");

  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK && !rem_gt_k) |=> (phase == PH_DIV))
    else $error("series step not entered");

endmodule
